FILE: hdl/xcfr_pkg.sv
// Shared constants and types of the XOR-checked frame receiver.
`default_nettype none

package xcfr_pkg;

  // Frame geometry
  localparam int NUM_WORDS   = 13;
  localparam int HDR_LEN     = 2;
  localparam int PAYLOAD_LEN = 2 * NUM_WORDS;
  localparam int CSUM_POS    = PAYLOAD_LEN + HDR_LEN;
  localparam int FRAME_LEN   = PAYLOAD_LEN + 5;

  // Widths
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 4;
  localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Line control bytes
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_CSUM_ERR = 1'b1;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_DRAIN,
    ST_ERR
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/xor_checked_frame_receiver_core.sv
// Top level of the XOR-checked frame receiver: byte collection, word memory and drain.
//
// The receiver takes one serial byte per cycle on the rx channel while rx_ready
// is high and collects fixed-length frames (two header bytes, 2*NUM_WORDS payload
// bytes, one XOR checksum byte, CR, LF). Payload bytes are written into a
// NUM_WORDS x 16-bit word memory, one byte lane at a time. Every byte other than a
// frame-ending LF gives no result. A frame-ending LF of a frame with the right
// length and a matching checksum starts a drain that reads the word memory through
// its single registered read port and gives NUM_WORDS results, one per cycle when
// res_ready stays high; rx_ready is low from the cycle after that LF until the last
// result is taken. A checksum mismatch gives one error result, and rx_ready stays
// low until it is taken. Frames of any other length are dropped silently. No
// clearing pass is run after reset.
`default_nettype none

module xor_checked_frame_receiver_core
  import xcfr_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  // byte input
  input  wire                     rx_valid,
  output logic                    rx_ready,
  input  wire  [7:0]              rx_byte,
  // result output
  output logic                    res_valid,
  input  wire                     res_ready,
  output logic [IDX_W-1:0]        word_index,
  output logic signed [15:0]      word_value,
  output logic                    status,
  output logic                    last
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [7:0]        running_xor, running_xor_next;
  logic              prev_was_cr, prev_was_cr_next;
  logic [7:0]        checksum_byte, checksum_byte_next;
  logic [ADDR_W-1:0] rd_idx, rd_idx_next;

  logic [15:0]       word_mem [NUM_WORDS];
  logic [15:0]       rd_data;

  logic              rx_fire, res_fire;
  logic              is_term, frame_ok, drain_last;
  logic              wr_en, wr_hi;
  logic [CNT_W-1:0]  wr_off;
  logic [ADDR_W-1:0] wr_addr;

  // Decode the incoming byte
  assign rx_fire    = rx_valid && rx_ready;
  assign res_fire   = res_valid && res_ready;
  assign is_term    = (rx_byte == BYTE_LF) && prev_was_cr;
  assign frame_ok   = (byte_count == CNT_W'(FRAME_LEN - 1));
  assign drain_last = (rd_idx == ADDR_W'(NUM_WORDS - 1));
  assign wr_off     = byte_count - CNT_W'(HDR_LEN);
  assign wr_addr    = wr_off[ADDR_W:1];
  assign wr_hi      = wr_off[0];

  // Hold state and frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RECV;
      byte_count    <= '0;
      running_xor   <= '0;
      prev_was_cr   <= 1'b0;
      checksum_byte <= '0;
      rd_idx        <= '0;
    end else begin
      state         <= state_next;
      byte_count    <= byte_count_next;
      running_xor   <= running_xor_next;
      prev_was_cr   <= prev_was_cr_next;
      checksum_byte <= checksum_byte_next;
      rd_idx        <= rd_idx_next;
    end
  end

  // Word memory: byte-lane writes, registered read at the next drain index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_hi) begin
        word_mem[wr_addr][15:8] <= rx_byte;
      end else begin
        word_mem[wr_addr][7:0] <= rx_byte;
      end
    end
    rd_data <= word_mem[rd_idx_next];
  end

  // Next state, frame bookkeeping and result fields
  always_comb begin
    state_next         = state;
    byte_count_next    = byte_count;
    running_xor_next   = running_xor;
    prev_was_cr_next   = prev_was_cr;
    checksum_byte_next = checksum_byte;
    rd_idx_next        = rd_idx;
    wr_en              = 1'b0;
    rx_ready           = 1'b0;
    res_valid          = 1'b0;
    word_index         = '0;
    word_value         = '0;
    status             = STATUS_OK;
    last               = 1'b0;

    case (state)
      ST_RECV: begin
        rx_ready = 1'b1;
        if (rx_fire) begin
          if (is_term) begin
            // close the frame; keep it only at the exact length
            byte_count_next    = '0;
            running_xor_next   = '0;
            prev_was_cr_next   = 1'b0;
            checksum_byte_next = '0;
            if (frame_ok) begin
              if (running_xor == checksum_byte) begin
                state_next  = ST_DRAIN;
                rd_idx_next = '0;
              end else begin
                state_next = ST_ERR;
              end
            end
          end else begin
            // store payload, latch checksum, advance the saturating count
            if (byte_count >= CNT_W'(HDR_LEN) && byte_count < CNT_W'(CSUM_POS)) begin
              wr_en            = 1'b1;
              running_xor_next = running_xor ^ rx_byte;
            end else if (byte_count == CNT_W'(CSUM_POS)) begin
              checksum_byte_next = rx_byte;
            end
            if (byte_count != COUNT_MAX) begin
              byte_count_next = byte_count + 1'b1;
            end
            prev_was_cr_next = (rx_byte == BYTE_CR);
          end
        end
      end

      ST_DRAIN: begin
        res_valid  = 1'b1;
        word_index = IDX_W'(rd_idx);
        word_value = $signed(rd_data);
        status     = STATUS_OK;
        last       = drain_last;
        if (res_fire) begin
          if (drain_last) begin
            state_next = ST_RECV;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
          end
        end
      end

      ST_ERR: begin
        res_valid  = 1'b1;
        word_index = '0;
        word_value = '0;
        status     = STATUS_CSUM_ERR;
        last       = 1'b1;
        if (res_fire) begin
          state_next = ST_RECV;
        end
      end

      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Never take a byte while a result is on offer
  assert property (@(posedge clk) disable iff (rst) !(rx_ready && res_valid))
    else $error("byte accepted while a result is pending");

  // Drain index stays inside the word memory
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (rd_idx <= ADDR_W'(NUM_WORDS - 1)))
    else $error("drain index beyond word memory");

  // Taking the final result reopens the byte channel
  assert property (@(posedge clk) disable iff (rst) (res_fire && last) |=> rx_ready)
    else $error("byte channel not reopened after final result");

  // A drained word carries an incrementing index
  assert property (@(posedge clk) disable iff (rst)
    (res_fire && !last && state == ST_DRAIN) |=>
      (word_index == $past(word_index) + 1'b1))
    else $error("drain index did not advance");
`endif

endmodule

`default_nettype wire
